// ----- rtl/block_buffer_tag_table_top_defines.svh -----
// ----------------------------------------------------------------------------
// block buffer tag table assertion macros
// clocked assertion forms used by the rtl datapath module
// ----------------------------------------------------------------------------
`ifndef BLOCK_BUFFER_TAG_TABLE_TOP_DEFINES_SVH
`define BLOCK_BUFFER_TAG_TABLE_TOP_DEFINES_SVH

// condition holds at every edge out of reset
`define BBT_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// consequent holds in the cycle after antecedent
`define BBT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bbt_pkg.sv -----
// ----------------------------------------------------------------------------
// bbt_pkg
// types and constants shared by the block buffer tag table modules
// ----------------------------------------------------------------------------
package bbt_pkg;

    localparam int NUM_BUFFERS_DEF = 16;
    localparam int DEVICE_W        = 16;
    localparam int SECTOR_W        = 32;
    localparam int SLOT_W          = 4;
    localparam int STATUS_W        = 3;
    localparam int TAG_W           = DEVICE_W + SECTOR_W;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT      = 3'd0,
        ST_NEW      = 3'd1,
        ST_WAIT     = 3'd2,
        ST_NOFREE   = 3'd3,
        ST_RELEASED = 3'd4,
        ST_RELERR   = 3'd5
    } status_t;

    typedef enum logic {
        ACT_ACQUIRE = 1'b0,
        ACT_RELEASE = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_stop;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ----- rtl/bbt_ram.sv -----
// ----------------------------------------------------------------------------
// bbt_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module bbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/bbt_ctrl.sv -----
// ----------------------------------------------------------------------------
// bbt_ctrl
// controller state machine: accept, tag scan, commit of the result
// ----------------------------------------------------------------------------
module bbt_ctrl
    import bbt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_action,
    output logic      s_ready,
    output ctrl_cmd_t cmd,
    input  ctrl_sts_t sts
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = (s_action == ACT_RELEASE) ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                if (sts.scan_stop) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd.load   = 1'b0;
        cmd.scan   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
            end
            S_FINISH: begin
                cmd.commit = sts.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/bbt_datapath.sv -----
// ----------------------------------------------------------------------------
// bbt_datapath
// tag ram, valid and busy flags, shared tag comparator and result register
// ----------------------------------------------------------------------------
`include "block_buffer_tag_table_top_defines.svh"

module bbt_datapath
    import bbt_pkg::*;
#(
    parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_action,
    input  logic [DEVICE_W-1:0] s_device,
    input  logic [SECTOR_W-1:0] s_sector,
    input  logic [SLOT_W-1:0]   s_slot,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [SLOT_W-1:0]   m_granted_slot,
    input  ctrl_cmd_t           cmd,
    output ctrl_sts_t           sts
);

    localparam int IDX_W = $clog2(NUM_BUFFERS);
    localparam int CMP_W = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;

    logic                req_action_reg;
    logic [DEVICE_W-1:0] req_device_reg;
    logic [SECTOR_W-1:0] req_sector_reg;
    logic [SLOT_W-1:0]   req_slot_reg;

    logic [NUM_BUFFERS-1:0] valid_reg;
    logic [NUM_BUFFERS-1:0] valid_next;
    logic [NUM_BUFFERS-1:0] busy_reg;
    logic [NUM_BUFFERS-1:0] busy_next;

    logic [IDX_W-1:0] scan_idx_reg;
    logic             match_found_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [SLOT_W-1:0]   m_slot_reg;

    logic             scan_last;
    logic             hit_now;
    logic [IDX_W-1:0] ram_raddr;
    logic [TAG_W-1:0] ram_rdata;
    logic             ram_we;

    logic [CMP_W-1:0] rel_ext;
    logic [IDX_W-1:0] rel_idx;
    logic             rel_ok;

    status_t          res_status;
    logic [IDX_W-1:0] res_idx;
    logic             res_has_slot;

    bbt_ram #(
        .WIDTH (TAG_W),
        .DEPTH (NUM_BUFFERS)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (free_idx_reg),
        .wdata ({req_device_reg, req_sector_reg}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // scan reads one entry ahead of the compare
    assign scan_last = (scan_idx_reg == IDX_W'(NUM_BUFFERS - 1));
    assign ram_raddr = (cmd.scan && !scan_last) ? scan_idx_reg + IDX_W'(1) : '0;
    assign hit_now   = cmd.scan && valid_reg[scan_idx_reg]
                       && (ram_rdata == {req_device_reg, req_sector_reg});

    assign sts.scan_stop = cmd.scan && (hit_now || scan_last);
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign rel_ext = CMP_W'(req_slot_reg);
    assign rel_idx = rel_ext[IDX_W-1:0];
    assign rel_ok  = (rel_ext < CMP_W'(NUM_BUFFERS)) && busy_reg[rel_idx];

    always_comb begin
        res_status   = ST_NOFREE;
        res_idx      = '0;
        res_has_slot = 1'b0;
        valid_next   = valid_reg;
        busy_next    = busy_reg;
        ram_we       = 1'b0;
        if (req_action_reg == ACT_RELEASE) begin
            if (rel_ok) begin
                res_status   = ST_RELEASED;
                res_idx      = rel_idx;
                res_has_slot = 1'b1;
                busy_next[rel_idx] = !cmd.commit;
            end else begin
                res_status = ST_RELERR;
            end
        end else if (match_found_reg) begin
            if (busy_reg[match_idx_reg]) begin
                res_status = ST_WAIT;
            end else begin
                res_status   = ST_HIT;
                res_idx      = match_idx_reg;
                res_has_slot = 1'b1;
                busy_next[match_idx_reg] = cmd.commit;
            end
        end else if (free_found_reg) begin
            res_status   = ST_NEW;
            res_idx      = free_idx_reg;
            res_has_slot = 1'b1;
            ram_we       = cmd.commit;
            if (cmd.commit) begin
                valid_next[free_idx_reg] = 1'b1;
                busy_next[free_idx_reg]  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            busy_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            busy_reg  <= busy_next;
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_action_reg  <= s_action;
            req_device_reg  <= s_device;
            req_sector_reg  <= s_sector;
            req_slot_reg    <= s_slot;
            scan_idx_reg    <= '0;
            match_found_reg <= 1'b0;
            match_idx_reg   <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
        end else if (cmd.scan) begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            if (hit_now) begin
                match_found_reg <= 1'b1;
                match_idx_reg   <= scan_idx_reg;
            end
            if (!free_found_reg && !busy_reg[scan_idx_reg]) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= scan_idx_reg;
            end
        end
        if (cmd.commit) begin
            m_status_reg <= res_status;
            m_slot_reg   <= res_has_slot ? SLOT_W'(res_idx) : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_granted_slot = m_slot_reg;

    `BBT_ASSERT_NEXT(a_scan_stops, cmd.scan && scan_last, !cmd.scan, "scan ran past last entry")
    `BBT_ASSERT_NEXT(a_new_marks_busy, cmd.commit && res_status == ST_NEW, busy_reg[$past(free_idx_reg)] && valid_reg[$past(free_idx_reg)], "new entry not marked valid and busy")
    `BBT_ASSERT_NEXT(a_release_clears, cmd.commit && res_status == ST_RELEASED, !busy_reg[$past(rel_idx)], "released slot still busy")

endmodule

// ----- rtl/block_buffer_tag_table_top.sv -----
// ----------------------------------------------------------------------------
// block_buffer_tag_table_top
// block buffer tag table: lookup and allocate by device and sector, release
//
// input channel s_*: action 0 acquires a buffer for (device, sector), action 1
// releases slot. result channel m_*: status and granted_slot, one per transaction.
// an acquire scans the tag ram one entry per cycle through a single comparator,
// stopping at the first valid match; the last cycle commits the result into the
// output register. an acquire passes from idle through scan to finish and back
// to idle, leaving the scan early on a match; a release goes from idle straight
// to finish. the commit in finish raises m_valid.
// one transaction is in work at a time; a finished result waits in the output
// register while the next transaction is accepted and scanned, and the commit
// holds while the receiver stalls. reset clears all valid and busy flags at
// once; the tag ram is not cleared, empty entries never match.
// ----------------------------------------------------------------------------
module block_buffer_tag_table_top
    import bbt_pkg::*;
#(
    parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_action,
    input  logic [DEVICE_W-1:0] s_device,
    input  logic [SECTOR_W-1:0] s_sector,
    input  logic [SLOT_W-1:0]   s_slot,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [SLOT_W-1:0]   m_granted_slot
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    bbt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    bbt_datapath #(
        .NUM_BUFFERS (NUM_BUFFERS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_action       (s_action),
        .s_device       (s_device),
        .s_sector       (s_sector),
        .s_slot         (s_slot),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_granted_slot (m_granted_slot),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

// ----- test/bbt_grant_checker.sv -----
// ----------------------------------------------------------------------------
// bbt_grant_checker
// watches both channels of the block buffer tag table, keeps its own copy of
// the tag entries, predicts the status and slot of every accepted transaction
// and compares each returned result in order against the oldest prediction
// ----------------------------------------------------------------------------
module bbt_grant_checker
    import bbt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic                s_action,
    input  logic [DEVICE_W-1:0] s_device,
    input  logic [SECTOR_W-1:0] s_sector,
    input  logic [SLOT_W-1:0]   s_slot,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [STATUS_W-1:0] m_status,
    input  logic [SLOT_W-1:0]   m_granted_slot,
    output int                  mismatch_count,
    output int                  grants_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
    } grant_t;

    logic [DEVICE_W-1:0] tag_device [NUM_BUFFERS_DEF];
    logic [SECTOR_W-1:0] tag_sector [NUM_BUFFERS_DEF];
    logic                tag_valid  [NUM_BUFFERS_DEF];
    logic                tag_busy   [NUM_BUFFERS_DEF];
    grant_t              expected_grants [$];

    function automatic grant_t lookup_allocate(action_t act, logic [DEVICE_W-1:0] dev,
                                               logic [SECTOR_W-1:0] sec,
                                               logic [SLOT_W-1:0] slot);
        grant_t g;
        int     match_idx;
        int     free_idx;
        g.status  = ST_NOFREE;
        g.slot    = '0;
        match_idx = -1;
        free_idx  = -1;
        if (act == ACT_RELEASE) begin
            if (int'(slot) < NUM_BUFFERS_DEF && tag_busy[slot]) begin
                tag_busy[slot] = 1'b0;
                g.status       = ST_RELEASED;
                g.slot         = slot;
            end else begin
                g.status = ST_RELERR;
            end
        end else begin
            for (int i = 0; i < NUM_BUFFERS_DEF; i++) begin
                if (match_idx < 0 && tag_valid[i] && tag_device[i] == dev
                        && tag_sector[i] == sec) begin
                    match_idx = i;
                end
                if (free_idx < 0 && !tag_busy[i]) begin
                    free_idx = i;
                end
            end
            if (match_idx >= 0) begin
                if (tag_busy[match_idx]) begin
                    g.status = ST_WAIT;
                end else begin
                    tag_busy[match_idx] = 1'b1;
                    g.status            = ST_HIT;
                    g.slot              = SLOT_W'(match_idx);
                end
            end else if (free_idx >= 0) begin
                tag_device[free_idx] = dev;
                tag_sector[free_idx] = sec;
                tag_valid[free_idx]  = 1'b1;
                tag_busy[free_idx]   = 1'b1;
                g.status             = ST_NEW;
                g.slot               = SLOT_W'(free_idx);
            end
        end
        return g;
    endfunction

    always @(posedge aclk) begin : monitor
        grant_t got;
        grant_t want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_BUFFERS_DEF; i++) begin
                tag_device[i] = '0;
                tag_sector[i] = '0;
                tag_valid[i]  = 1'b0;
                tag_busy[i]   = 1'b0;
            end
            expected_grants.delete();
        end else begin
            if (m_valid && m_ready) begin
                got.status = status_t'(m_status);
                got.slot   = m_granted_slot;
                if (expected_grants.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected transaction, status %0d slot %0d",
                             $time, m_status, m_granted_slot);
                end else begin
                    want = expected_grants.pop_front();
                    if (got.status != want.status) begin
                        mismatch_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_status);
                    end
                    if (got.slot != want.slot) begin
                        mismatch_count++;
                        $display("%0t: granted_slot expected %0d actual %0d",
                                 $time, want.slot, m_granted_slot);
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_grants.push_back(lookup_allocate(action_t'(s_action), s_device,
                                                          s_sector, s_slot));
            end
        end
        grants_pending = expected_grants.size();
    end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// drives the block buffer tag table with directed acquire and release
// transactions, then random ones drawn mostly from a small tag pool so that
// hits, waits, evictions and full tables recur, under several idle and stall
// patterns including one long result hold-off; the checker gives the verdict
// ----------------------------------------------------------------------------
module tb_top
    import bbt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 260;
    localparam int TAG_POOL        = 24;
    localparam int HOLD_CYCLES     = 300;
    localparam int STALL_LIMIT     = 3000;
    localparam int DRAIN_CYCLES    = 40;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_action;
    logic [DEVICE_W-1:0] s_device;
    logic [SECTOR_W-1:0] s_sector;
    logic [SLOT_W-1:0]   s_slot;
    logic                m_valid;
    logic                m_ready;
    logic [STATUS_W-1:0] m_status;
    logic [SLOT_W-1:0]   m_granted_slot;
    int                  mismatch_count;
    int                  grants_pending;

    int                  phase;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    logic [DEVICE_W-1:0] pool_device [TAG_POOL];
    logic [SECTOR_W-1:0] pool_sector [TAG_POOL];

    block_buffer_tag_table_top uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_device       (s_device),
        .s_sector       (s_sector),
        .s_slot         (s_slot),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_granted_slot (m_granted_slot)
    );

    bbt_grant_checker grant_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_device       (s_device),
        .s_sector       (s_sector),
        .s_slot         (s_slot),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_granted_slot (m_granted_slot),
        .mismatch_count (mismatch_count),
        .grants_pending (grants_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    task automatic offer(action_t act, logic [DEVICE_W-1:0] dev, logic [SECTOR_W-1:0] sec,
                         logic [SLOT_W-1:0] slot);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_action <= act;
        s_device <= dev;
        s_sector <= sec;
        s_slot   <= slot;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic random_transaction();
        int k;
        k = $urandom_range(TAG_POOL - 1);
        if ($urandom_range(1) == 1) begin
            offer(ACT_RELEASE, DEVICE_W'($urandom), SECTOR_W'($urandom),
                  SLOT_W'($urandom_range(15)));
        end else if ($urandom_range(99) < 85) begin
            offer(ACT_ACQUIRE, pool_device[k], pool_sector[k], SLOT_W'($urandom_range(15)));
        end else begin
            offer(ACT_ACQUIRE, DEVICE_W'($urandom), SECTOR_W'($urandom),
                  SLOT_W'($urandom_range(15)));
        end
    endtask

    // result side: random stalls plus one long hold-off to back up the input
    initial begin : result_sink
        bit hold_done;
        hold_done = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (phase == 2 && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_top failed");
        $finish;
    end

    initial begin : stimulus
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_action       = ACT_ACQUIRE;
        s_device       = '0;
        s_sector       = '0;
        s_slot         = '0;
        phase          = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pool_device[0] = '0;
        pool_sector[0] = '0;
        pool_device[1] = '1;
        pool_sector[1] = '1;
        for (int i = 2; i < TAG_POOL; i++) begin
            pool_device[i] = DEVICE_W'($urandom);
            pool_sector[i] = SECTOR_W'($urandom);
        end
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty entries must not match the zero tag
        offer(ACT_ACQUIRE, '0, '0, '0);
        offer(ACT_ACQUIRE, '0, '0, '1);
        offer(ACT_RELEASE, '1, '1, 4'd0);
        offer(ACT_ACQUIRE, '0, '0, '0);
        offer(ACT_RELEASE, '0, '0, 4'd5);
        offer(ACT_ACQUIRE, '1, '1, '0);
        for (int i = 0; i < 14; i++) begin
            offer(ACT_ACQUIRE, DEVICE_W'(i + 1), SECTOR_W'(32'h8000_0000 | i), SLOT_W'(i));
        end
        // table full: miss gets no free, busy match gets wait
        offer(ACT_ACQUIRE, 16'h1234, 32'h5678_9abc, '0);
        offer(ACT_ACQUIRE, '1, '1, '0);
        offer(ACT_RELEASE, '0, '0, 4'd15);
        offer(ACT_RELEASE, '0, '0, 4'd15);
        offer(ACT_ACQUIRE, 16'h1234, 32'h5678_9abc, '0);

        for (int p = 0; p < 4; p++) begin
            phase = p;
            case (p)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 64;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 64;
                end
                default: begin
                    send_idle_pct  = 25;
                    recv_stall_pct = 25;
                end
            endcase
            repeat (ITEMS_PER_PHASE) random_transaction();
        end
        s_valid <= 1'b0;

        wait (grants_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && grants_pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
